// ===== design/pdc_pkg.sv =====
// shared constants, register codes and stage payload types of the duty controller
package pdc_pkg;

    // voltage format: signed Q(32-F).F
    localparam int VOLT_FRAC_BITS = 16;

    // setpoint conversion from unsigned 32.32
    localparam int SP_SHIFT = 32 - VOLT_FRAC_BITS;
    localparam int SP_W     = 64 - SP_SHIFT;

    // signed gain term after the Q.F drop, and the sum of both terms
    localparam int TERM_W = 65 - VOLT_FRAC_BITS;
    localparam int SUM_W  = TERM_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 3'd4;

    // register reset values
    localparam logic [31:0] KP_GAIN_RST       = 32'd42949673;
    localparam logic [31:0] KI_GAIN_RST       = 32'd429497;
    localparam logic [31:0] DUTY_MIN_RST      = 32'd0;
    localparam logic [31:0] DUTY_MAX_RST      = 32'd3865470566;
    localparam logic [15:0] REPORT_PERIOD_RST = 16'd10;

    // setpoint saturation value, the Q(32-F).F maximum
    localparam logic [31:0] TARGET_MAX = 32'h7FFF_FFFF;

    // clamp status codes
    localparam logic [1:0] LIMIT_NONE = 2'd0;
    localparam logic [1:0] LIMIT_LOW  = 2'd1;
    localparam logic [1:0] LIMIT_HIGH = 2'd2;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [31:0] kp_gain;
        logic [31:0] ki_gain;
        logic [31:0] duty_min;
        logic [31:0] duty_max;
        logic [15:0] report_period;
    } cfg_t;

    // error stage: sign and magnitude of the error
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic [31:0] meas;
    } err_t;

    // product stage: raw gain products
    typedef struct packed {
        logic        neg;
        logic [63:0] kp_prod;
        logic [63:0] ki_prod;
        logic [31:0] meas;
    } prod_t;

    // term stage: signed integral term and signed sum of both terms
    typedef struct packed {
        logic signed [TERM_W-1:0] ki_term;
        logic signed [SUM_W-1:0]  term_sum;
        logic [31:0]              meas;
    } term_t;

    // one result item
    typedef struct packed {
        logic [31:0] duty_value;
        logic [1:0]  limit_hit;
        logic        report_valid;
        logic [31:0] report_voltage;
    } result_t;

endpackage

// ===== design/pdc_front.sv =====
// input register, setpoint update and error stage
module pdc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_action,
    input  logic [31:0]       in_meas,
    input  logic [63:0]       in_payload,
    output logic              err_valid,
    input  logic              err_ready,
    output pdc_pkg::err_t     err_data
);
    import pdc_pkg::*;

    logic        a_valid_reg, a_valid_next;
    logic        a_action_reg;
    logic [31:0] a_meas_reg;
    logic [63:0] a_payload_reg;
    logic        b_valid_reg, b_valid_next;
    err_t        b_data_reg;
    logic [31:0] target_reg, target_next;

    logic        a_done;
    logic        b_load;
    logic        in_fire;
    logic [SP_W-1:0]  sp_full;
    logic signed [32:0] err;
    logic signed [32:0] err_neg;
    err_t        b_data_next;

    // a setpoint update always leaves the input stage, a tick waits for the error stage
    assign b_load   = a_valid_reg && !a_action_reg && (!b_valid_reg || err_ready);
    assign a_done   = a_valid_reg && (a_action_reg || !b_valid_reg || err_ready);
    assign in_ready = !a_valid_reg || a_done;
    assign in_fire  = in_valid && in_ready;

    // setpoint conversion with saturation
    assign sp_full = a_payload_reg[63:SP_SHIFT];
    always_comb begin
        target_next = target_reg;
        if (a_done && a_action_reg) begin
            if (|sp_full[SP_W-1:31]) begin
                target_next = TARGET_MAX;
            end else begin
                target_next = sp_full[31:0];
            end
        end
    end

    // error as sign and magnitude
    assign err     = {target_reg[31], target_reg} - {a_meas_reg[31], a_meas_reg};
    assign err_neg = -err;
    always_comb begin
        b_data_next.neg  = err[32];
        b_data_next.mag  = err[32] ? err_neg[31:0] : err[31:0];
        b_data_next.meas = a_meas_reg;
    end

    // stage valid flags
    always_comb begin
        a_valid_next = a_valid_reg;
        if (in_fire) begin
            a_valid_next = 1'b1;
        end else if (a_done) begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (b_load) begin
            b_valid_next = 1'b1;
        end else if (err_ready) begin
            b_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            target_reg  <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            target_reg  <= target_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            a_action_reg  <= in_action;
            a_meas_reg    <= in_meas;
            a_payload_reg <= in_payload;
        end
        if (b_load) begin
            b_data_reg <= b_data_next;
        end
    end

    assign err_valid = b_valid_reg;
    assign err_data  = b_data_reg;

endmodule

// ===== design/pdc_mult.sv =====
// gain multipliers and signed term stage
module pdc_mult (
    input  logic              aclk,
    input  logic              aresetn,
    input  pdc_pkg::cfg_t     cfg,
    input  logic              err_valid,
    output logic              err_ready,
    input  pdc_pkg::err_t     err_data,
    output logic              term_valid,
    input  logic              term_ready,
    output pdc_pkg::term_t    term_data
);
    import pdc_pkg::*;

    logic  c_valid_reg, c_valid_next;
    prod_t c_data_reg;
    logic  d_valid_reg, d_valid_next;
    term_t d_data_reg;

    logic  c_load;
    logic  d_load;
    logic  d_ready;
    prod_t c_data_next;
    term_t d_data_next;
    logic signed [TERM_W-1:0] kp_mag;
    logic signed [TERM_W-1:0] ki_mag;
    logic signed [TERM_W-1:0] kp_term;
    logic signed [TERM_W-1:0] ki_term;

    assign d_ready   = !d_valid_reg || term_ready;
    assign err_ready = !c_valid_reg || d_ready;
    assign c_load    = err_valid && err_ready;
    assign d_load    = c_valid_reg && d_ready;

    // 32x32 products of the error magnitude and the gains
    always_comb begin
        c_data_next.neg     = err_data.neg;
        c_data_next.kp_prod = err_data.mag * cfg.kp_gain;
        c_data_next.ki_prod = err_data.mag * cfg.ki_gain;
        c_data_next.meas    = err_data.meas;
    end

    // drop the voltage fraction bits, truncating the magnitude, then apply the sign
    assign kp_mag  = {1'b0, c_data_reg.kp_prod[63:VOLT_FRAC_BITS]};
    assign ki_mag  = {1'b0, c_data_reg.ki_prod[63:VOLT_FRAC_BITS]};
    assign kp_term = c_data_reg.neg ? -kp_mag : kp_mag;
    assign ki_term = c_data_reg.neg ? -ki_mag : ki_mag;
    always_comb begin
        d_data_next.ki_term  = ki_term;
        d_data_next.term_sum = {ki_term[TERM_W-1], ki_term} + {kp_term[TERM_W-1], kp_term};
        d_data_next.meas     = c_data_reg.meas;
    end

    // stage valid flags
    always_comb begin
        c_valid_next = c_valid_reg;
        if (c_load) begin
            c_valid_next = 1'b1;
        end else if (d_ready) begin
            c_valid_next = 1'b0;
        end
        d_valid_next = d_valid_reg;
        if (d_load) begin
            d_valid_next = 1'b1;
        end else if (term_ready) begin
            d_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_load) begin
            c_data_reg <= c_data_next;
        end
        if (d_load) begin
            d_data_reg <= d_data_next;
        end
    end

    assign term_valid = d_valid_reg;
    assign term_data  = d_data_reg;

endmodule

// ===== design/pdc_accum.sv =====
// integrator, duty clamp, report counter and result register
module pdc_accum (
    input  logic              aclk,
    input  logic              aresetn,
    input  pdc_pkg::cfg_t     cfg,
    input  logic              term_valid,
    output logic              term_ready,
    input  pdc_pkg::term_t    term_data,
    output logic              res_valid,
    input  logic              res_ready,
    output pdc_pkg::result_t  res_data
);
    import pdc_pkg::*;

    logic signed [63:0] integrator_reg, integrator_next;
    logic [15:0]        tick_cnt_reg, tick_cnt_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg;

    logic               load;
    logic signed [63:0] ki_ext;
    logic signed [63:0] sum_ext;
    logic signed [63:0] int_sum;
    logic signed [63:0] y;
    logic               clamp_low;
    logic               clamp_high;
    logic [16:0]        cnt;
    logic               report;
    result_t            out_data_next;

    assign term_ready = !out_valid_reg || res_ready;
    assign load       = term_valid && term_ready;

    // integrator candidate and controller output
    assign ki_ext  = {{(64-TERM_W){term_data.ki_term[TERM_W-1]}}, term_data.ki_term};
    assign sum_ext = {{(64-SUM_W){term_data.term_sum[SUM_W-1]}}, term_data.term_sum};
    assign int_sum = integrator_reg + ki_ext;
    assign y       = integrator_reg + sum_ext;

    // clamp tests, low limit first
    assign clamp_low  = y < $signed({32'd0, cfg.duty_min});
    assign clamp_high = y > $signed({32'd0, cfg.duty_max});

    // report period counter
    assign cnt    = {1'b0, tick_cnt_reg} + 17'd1;
    assign report = cnt >= {1'b0, cfg.report_period};

    always_comb begin
        integrator_next = integrator_reg;
        tick_cnt_next   = tick_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_data_next.report_valid   = report;
        out_data_next.report_voltage = report ? term_data.meas : 32'd0;
        if (clamp_low) begin
            out_data_next.duty_value = cfg.duty_min;
            out_data_next.limit_hit  = LIMIT_LOW;
        end else if (clamp_high) begin
            out_data_next.duty_value = cfg.duty_max;
            out_data_next.limit_hit  = LIMIT_HIGH;
        end else begin
            out_data_next.duty_value = y[31:0];
            out_data_next.limit_hit  = LIMIT_NONE;
        end
        if (load) begin
            out_valid_next = 1'b1;
            tick_cnt_next  = report ? 16'd0 : cnt[15:0];
            // anti-windup: integrate only when the output is in range
            if (!clamp_low && !clamp_high) begin
                integrator_next = int_sum;
            end
        end else if (res_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integrator_reg <= '0;
            tick_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            integrator_reg <= integrator_next;
            tick_cnt_reg   <= tick_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

// ===== design/pi_duty_controller_clamped_top.sv =====
// top level of the clamped pi duty controller
//
// PI duty regulator with conditional integration. A transaction with s_tuser set
// loads a new setpoint (unsigned 32.32, saturated to the Q16.16 maximum) and
// gives no result; a transaction with s_tuser clear is a control tick that
// returns one result from the output register of the last stage. The block takes
// one transaction per clock cycle while results are taken: the input register,
// error stage, multiplier stage, term stage and accumulate stage each hold one
// item; the integrator add and duty clamp are combinational in the last stage.
// A result waiting in the output register does not block new input until every
// stage is full. Configuration registers must be written by the user through
// cfg_wr_en/cfg_addr/cfg_wdata only while no transaction is in flight; the block does not enforce it.
module pi_duty_controller_clamped_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [95:0]                         s_tdata,   // measured_voltage, setpoint_payload
    input  logic [0:0]                          s_tuser,   // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [71:0]                         m_tdata,   // duty_value, limit_hit, report_voltage
    output logic [0:0]                          m_tuser    // report_valid
);
    import pdc_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    err_valid, err_ready;
    err_t    err_data;
    logic    term_valid, term_ready;
    term_t   term_data;
    result_t res_data;

    // configuration register writes, unknown indexes ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KP_GAIN:       cfg_next.kp_gain       = cfg_wdata;
                REG_KI_GAIN:       cfg_next.ki_gain       = cfg_wdata;
                REG_DUTY_MIN:      cfg_next.duty_min      = cfg_wdata;
                REG_DUTY_MAX:      cfg_next.duty_max      = cfg_wdata;
                REG_REPORT_PERIOD: cfg_next.report_period = cfg_wdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain       <= KP_GAIN_RST;
            cfg_reg.ki_gain       <= KI_GAIN_RST;
            cfg_reg.duty_min      <= DUTY_MIN_RST;
            cfg_reg.duty_max      <= DUTY_MAX_RST;
            cfg_reg.report_period <= REPORT_PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input register and error stage
    pdc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser[0]),
        .in_meas    (s_tdata[31:0]),
        .in_payload (s_tdata[95:32]),
        .err_valid  (err_valid),
        .err_ready  (err_ready),
        .err_data   (err_data)
    );

    // gain products and signed terms
    pdc_mult u_mult (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .err_valid  (err_valid),
        .err_ready  (err_ready),
        .err_data   (err_data),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term_data  (term_data)
    );

    // integrator, clamp and result register
    pdc_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term_data  (term_data),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_data   (res_data)
    );

    // result packing
    assign m_tdata = {6'd0, res_data.report_voltage, res_data.limit_hit, res_data.duty_value};
    assign m_tuser = res_data.report_valid;

endmodule

// ===== design/pdc_checker.sv =====
// port-level assertions for the duty controller and their bind
module pdc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [71:0]                         m_tdata,
    input logic [0:0]                          m_tuser
);
    import pdc_pkg::*;

    // no result is shown in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // clamp status only takes its defined codes
    a_limit_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:32] == LIMIT_NONE || m_tdata[33:32] == LIMIT_LOW ||
                      m_tdata[33:32] == LIMIT_HIGH))
        else $error("undefined limit code");

    // voltage is only reported with the report flag
    a_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[65:34] == 32'd0))
        else $error("report voltage without report flag");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind pi_duty_controller_clamped_top pdc_checker u_checker (.*);

// ===== tb/tb_pi_duty_controller_clamped_top.sv =====
// self-checking testbench for the clamped pi duty controller top level
`timescale 1ns / 100ps

module tb_pi_duty_controller_clamped_top;

    import pdc_pkg::*;

    localparam int PIPE_LATENCY   = 5;
    localparam int SETTLE_CYCLES  = 3 * PIPE_LATENCY;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 160;
    localparam int RANDOM_PHASES  = 12;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [95:0]           s_tdata   = '0;   // measured_voltage, setpoint_payload
    logic [0:0]            s_tuser   = '0;   // action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [71:0]           m_tdata;          // duty_value, limit_hit, report_voltage
    logic [0:0]            m_tuser;          // report_valid

    pi_duty_controller_clamped_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // shadow registers and regulator state
    logic [31:0]    kp_shadow     = KP_GAIN_RST;
    logic [31:0]    ki_shadow     = KI_GAIN_RST;
    logic [31:0]    dmin_shadow   = DUTY_MIN_RST;
    logic [31:0]    dmax_shadow   = DUTY_MAX_RST;
    logic [15:0]    period_shadow = REPORT_PERIOD_RST;
    longint signed  integ_state   = 0;
    logic [31:0]    target_state  = '0;
    logic [15:0]    tick_count    = '0;

    result_t        expected_duty_q[$];

    int error_count   = 0;
    int ticks_sent    = 0;
    int updates_sent  = 0;
    int cfg_settings  = 0;
    int seen_in_range = 0;
    int seen_low      = 0;
    int seen_high     = 0;
    int seen_reports  = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;

    // error times unsigned Q0.32 gain, magnitude truncated, result in Q.32
    function automatic longint signed gain_product(longint signed err, logic [31:0] gain);
        logic [63:0]   mag;
        logic [63:0]   prod;
        longint signed t;
        mag  = (err < 0) ? -err : err;
        prod = mag * {32'd0, gain};
        t    = $signed(prod >> VOLT_FRAC_BITS);
        return (err < 0) ? -t : t;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            REG_KP_GAIN:       kp_shadow     = val;
            REG_KI_GAIN:       ki_shadow     = val;
            REG_DUTY_MIN:      dmin_shadow   = val;
            REG_DUTY_MAX:      dmax_shadow   = val;
            REG_REPORT_PERIOD: period_shadow = val[15:0];
            default: ;
        endcase
    endfunction

    // expected duty result of one accepted transaction
    function automatic void predict_duty(logic act, logic [31:0] meas, logic [63:0] pay);
        logic [63:0]   sp;
        int signed     meas_i;
        longint signed err;
        longint signed next_integ;
        longint signed y;
        int            cnt;
        logic          rep;
        result_t       res;
        if (act) begin
            sp = pay >> SP_SHIFT;
            target_state = (sp > {32'd0, TARGET_MAX}) ? TARGET_MAX : sp[31:0];
            return;
        end
        meas_i     = meas;
        err        = longint'(int'(target_state)) - longint'(meas_i);
        next_integ = integ_state + gain_product(err, ki_shadow);
        y          = gain_product(err, kp_shadow) + next_integ;
        if (y < $signed({32'd0, dmin_shadow})) begin
            res.duty_value = dmin_shadow;
            res.limit_hit  = LIMIT_LOW;
        end else if (y > $signed({32'd0, dmax_shadow})) begin
            res.duty_value = dmax_shadow;
            res.limit_hit  = LIMIT_HIGH;
        end else begin
            res.duty_value = y[31:0];
            res.limit_hit  = LIMIT_NONE;
            integ_state    = next_integ;
        end
        cnt = int'(tick_count) + 1;
        rep = (cnt >= int'(period_shadow));
        tick_count         = rep ? 16'd0 : cnt[15:0];
        res.report_valid   = rep;
        res.report_voltage = rep ? meas : 32'd0;
        expected_duty_q.push_back(res);
    endfunction

    // input monitor: every accepted transaction feeds the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_duty(s_tuser[0], s_tdata[31:0], s_tdata[95:32]);
        end
    end

    // result checker
    always @(posedge aclk) begin : check_duty
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_duty_q.size() == 0) begin
                $display("%0t: unexpected result, actual duty %h limit %0d report %0d volt %h",
                         $time, m_tdata[31:0], m_tdata[33:32], m_tuser[0], m_tdata[65:34]);
                error_count++;
            end else begin
                want = expected_duty_q.pop_front();
                if (m_tdata[31:0] !== want.duty_value) begin
                    $display("%0t: duty_value expected %h actual %h",
                             $time, want.duty_value, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[33:32] !== want.limit_hit) begin
                    $display("%0t: limit_hit expected %0d actual %0d",
                             $time, want.limit_hit, m_tdata[33:32]);
                    error_count++;
                end
                if (m_tuser[0] !== want.report_valid) begin
                    $display("%0t: report_valid expected %0d actual %0d",
                             $time, want.report_valid, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[65:34] !== want.report_voltage) begin
                    $display("%0t: report_voltage expected %h actual %h",
                             $time, want.report_voltage, m_tdata[65:34]);
                    error_count++;
                end
            end
            case (m_tdata[33:32])
                LIMIT_LOW:  seen_low++;
                LIMIT_HIGH: seen_high++;
                default:    seen_in_range++;
            endcase
            if (m_tuser[0]) seen_reports++;
        end
    end

    // receiver back-pressure: modes of steady, light and heavy stalling
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_duty_q.size());
                $display("FAIL pi_duty_controller_clamped_top");
                $finish;
            end
        end
    end

    // one input transaction, sent in bursts with random gaps
    task automatic send_item(input logic act, input logic [31:0] meas,
                             input logic [63:0] pay);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pay, meas};
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (act) updates_sent++;
        else ticks_sent++;
    endtask

    task automatic send_tick(input logic [31:0] meas);
        send_item(1'b0, meas, {$urandom, $urandom});
    endtask

    task automatic send_setpoint(input logic [63:0] pay);
        send_item(1'b1, $urandom, pay);
    endtask

    // stop sending and let the pipeline run empty
    task automatic settle_block();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_duty_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_register(idx, val);
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] dmin, input logic [31:0] dmax,
                                input logic [31:0] period);
        settle_block();
        write_reg(REG_KP_GAIN, kp);
        write_reg(REG_KI_GAIN, ki);
        write_reg(REG_DUTY_MIN, dmin);
        write_reg(REG_DUTY_MAX, dmax);
        write_reg(REG_REPORT_PERIOD, period);
        cfg_settings++;
    endtask

    function automatic logic [31:0] scaled_rand();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // random transaction: mostly ticks near the setpoint, some noise and setpoints
    task automatic random_item();
        int            r;
        int            sh;
        longint signed err;
        logic [31:0]   meas;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            send_setpoint({24'd0, 8'($urandom), $urandom});
        end else if (r < 11) begin
            send_setpoint({$urandom, $urandom});
        end else if (r < 85) begin
            sh  = $urandom_range(0, 32);
            err = longint'({$urandom, $urandom}) & ((64'd1 << sh) - 1);
            if ($urandom_range(0, 2) == 0) err = -err;
            meas = target_state - err[31:0];
            send_tick(meas);
        end else begin
            send_tick($urandom);
        end
    endtask

    // reset register values: extremes of the fields, saturation and truncation
    task automatic test_default_regulation();
        send_tick(32'h0000_0000);
        send_tick(32'h8000_0000);
        send_tick(32'h7FFF_FFFF);
        send_setpoint(64'hFFFF_FFFF_FFFF_FFFF);
        send_tick(32'h0000_0000);
        send_tick(32'h8000_0000);
        send_setpoint(64'h0000_0000_0000_0000);
        send_tick(32'hFFFF_0000);
        // fraction bits below Q16.16 are truncated away
        send_setpoint({32'd48, 32'h8000_FFFF});
        send_tick({16'd47, 16'h8000});
        send_tick({16'd20, 16'h0000});
        send_setpoint({32'd12, 32'h0000_FFFF});
        send_tick({16'd12, 16'h0000});
        send_tick({16'd11, 16'hF000});
        // just above the saturation point
        send_setpoint(64'h0000_8000_0000_0000);
        send_tick({16'd300, 16'h0000});
        settle_block();
    endtask

    // unused indexes, inverted clamp window, zero and lowered report period
    task automatic test_special_cases();
        for (int a = int'(REG_REPORT_PERIOD) + 1; a < (1 << CFG_IDX_W); a++) begin
            write_reg(a[CFG_IDX_W-1:0], 32'hFFFF_FFFF);
            write_reg(a[CFG_IDX_W-1:0], 32'h0000_0000);
        end
        send_setpoint({32'd24, 32'd0});
        send_tick({16'd23, 16'd0});
        program_regs(KP_GAIN_RST, KI_GAIN_RST, 32'h8000_0000, 32'h4000_0000, 32'd0);
        send_tick({16'd24, 16'd0});
        send_tick({16'd0, 16'd0});
        send_tick(32'h8000_0000);
        program_regs(KP_GAIN_RST, KI_GAIN_RST, 32'd0, 32'hFFFF_FFFF, 32'd65535);
        repeat (5) send_tick({16'd23, 16'd0});
        program_regs(KP_GAIN_RST, KI_GAIN_RST, 32'd0, 32'hFFFF_FFFF, 32'd3);
        send_tick({16'd22, 16'd0});
        send_tick({16'd25, 16'd0});
        settle_block();
    endtask

    // random transactions over extreme and random register settings
    task automatic test_random_regulation();
        logic [31:0] lo;
        logic [31:0] hi;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: program_regs(KP_GAIN_RST, KI_GAIN_RST, DUTY_MIN_RST, DUTY_MAX_RST,
                                32'(REPORT_PERIOD_RST));
                1: program_regs(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
                2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF);
                3: program_regs(32'd0, 32'hFFFF_FFFF, 32'h1000_0000, 32'hF000_0000, 32'd7);
                4: program_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
                default: begin
                    lo = scaled_rand();
                    hi = ($urandom_range(0, 5) == 0) ? scaled_rand() : lo + scaled_rand();
                    if (hi < lo && $urandom_range(0, 1) == 0) hi = 32'hFFFF_FFFF;
                    program_regs(scaled_rand(), scaled_rand(), lo, hi,
                                 ($urandom_range(0, 4) == 0) ?
                                     $urandom : {16'($urandom), 16'($urandom_range(1, 16))});
                end
            endcase
            repeat (PHASE_ITEMS) random_item();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_regulation();
        test_special_cases();
        test_random_regulation();
        settle_block();
        $display("covered %0d ticks and %0d setpoint updates over %0d register settings",
                 ticks_sent, updates_sent, cfg_settings);
        $display("results: %0d in range, %0d clamped low, %0d clamped high, %0d reports",
                 seen_in_range, seen_low, seen_high, seen_reports);
        if (error_count == 0) begin
            $display("PASS pi_duty_controller_clamped_top");
        end else begin
            $display("FAIL pi_duty_controller_clamped_top");
        end
        $finish;
    end

endmodule
